@@ rtl/mmtpq_pkg.sv @@
// Shared types and codes for the min-max tree priority queue.
`default_nettype none
package mmtpq_pkg;

  localparam int unsigned CAPACITY = 127;
  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned OCC_W    = 7;
  localparam int unsigned STAT_W   = 2;

  // request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // one tree node: value plus subtree marks
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] smin;
    logic [VALUE_W-1:0] smax;
  } node_t;

endpackage
`default_nettype wire

@@ rtl/min_max_tree_priority_queue.sv @@
// Top level: min-max tree priority queue with insert and remove-min.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | to block  | in_valid_i / in_stall_o | cmd_i, value_i
//  out     | from block| out_valid_o/ out_stall_i| result_value_o, status_o, occupancy_o
//
// One request at a time. Every node visit goes through the single node RAM:
// an insert appends a leaf, then recomputes the marks of each ancestor; a
// remove descends along minimum marks, moves the last value into the freed
// slot, then recomputes the marks along both ancestor paths. Refused
// requests (full or empty) go straight to the result. Reset clears the
// control state, the count and the output valid; node RAM needs no clearing.
// The next request is taken while a result waits on a stalled output.
`default_nettype none
module min_max_tree_priority_queue (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             cmd_i,
  input  wire logic [mmtpq_pkg::VALUE_W-1:0]    value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [mmtpq_pkg::VALUE_W-1:0]    result_value_o,
  output logic      [mmtpq_pkg::STAT_W-1:0]     status_o,
  output logic      [mmtpq_pkg::OCC_W-1:0]      occupancy_o
);

  localparam int unsigned DEPTH = mmtpq_pkg::CAPACITY + 1;
  localparam int unsigned CW    = $clog2(DEPTH);
  localparam int unsigned VW    = mmtpq_pkg::VALUE_W;
  localparam int unsigned OW    = mmtpq_pkg::OCC_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_DRD   = 11'b000_0000_0010,
    S_DCHK  = 11'b000_0000_0100,
    S_DCMPL = 11'b000_0000_1000,
    S_LAST  = 11'b000_0001_0000,
    S_FILL  = 11'b000_0010_0000,
    S_RSELF = 11'b000_0100_0000,
    S_RL    = 11'b000_1000_0000,
    S_RR    = 11'b001_0000_0000,
    S_RW    = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d, ol_q, ol_d, rk_q, rk_d;
  logic          pend_q, pend_d;
  logic [VW-1:0] lo_q, lo_d, hi_q, hi_d, kv_q, kv_d;
  logic [VW-1:0] pv_q, pv_d, pmin_q, pmin_d, pmax_q, pmax_d;
  logic [VW-1:0] res_q, res_d;
  logic [mmtpq_pkg::STAT_W-1:0] stat_q, stat_d;
  logic          ov_q;
  logic [VW-1:0] ores_q;
  logic [mmtpq_pkg::STAT_W-1:0] ostat_q;
  logic [OW-1:0] oocc_q;

  // RAM port
  logic              we;
  logic [CW-1:0]     waddr, raddr;
  mmtpq_pkg::node_t  wdata, rdata;

  mmtpq_ram #(.WIDTH($bits(mmtpq_pkg::node_t)), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // child addresses and their presence
  logic [CW:0]   cnt_w, rk_l, rk_r, pos_l, pos_r;
  logic          rk_lv, rk_rv, pos_lv, pos_rv;
  logic [CW-1:0] cnt_inc;
  logic [VW-1:0] lo_n, hi_n;
  logic [CW+OW-1:0] cnt_ext;
  logic          in_acc, load_out;

  assign cnt_w   = {1'b0, cnt_q};
  assign rk_l    = {rk_q, 1'b0};
  assign rk_r    = {rk_q, 1'b1};
  assign pos_l   = {pos_q, 1'b0};
  assign pos_r   = {pos_q, 1'b1};
  assign rk_lv   = rk_l <= cnt_w;
  assign rk_rv   = rk_r <= cnt_w;
  assign pos_lv  = pos_l <= cnt_w;
  assign pos_rv  = pos_r <= cnt_w;
  assign cnt_inc = cnt_q + CW'(1);
  assign cnt_ext = {{OW{1'b0}}, cnt_q};

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_out   = (state_q == S_DONE) && (!ov_q || !out_stall_i);

  // fold right child into marks at the write step
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (rk_rv) begin
      if (rdata.smin < lo_n) lo_n = rdata.smin;
      if (rdata.smax > hi_n) hi_n = rdata.smax;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ol_d    = ol_q;
    rk_d    = rk_q;
    pend_d  = pend_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    kv_d    = kv_q;
    pv_d    = pv_q;
    pmin_d  = pmin_q;
    pmax_d  = pmax_q;
    res_d   = res_q;
    stat_d  = stat_q;
    we      = 1'b0;
    waddr   = rk_q;
    wdata   = '{value: kv_q, smin: lo_n, smax: hi_n};
    raddr   = rk_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d  = '0;
          stat_d = mmtpq_pkg::STAT_OK;
          if (cmd_i == mmtpq_pkg::CMD_INSERT) begin
            if (cnt_q == CW'(mmtpq_pkg::CAPACITY)) begin
              stat_d  = mmtpq_pkg::STAT_FULL;
              state_d = S_DONE;
            end else begin
              // append leaf, then repair its ancestors
              we     = 1'b1;
              waddr  = cnt_inc;
              wdata  = '{value: value_i, smin: value_i, smax: value_i};
              cnt_d  = cnt_inc;
              rk_d   = cnt_inc >> 1;
              pend_d = 1'b0;
              ol_d   = '0;
              state_d = ((cnt_inc >> 1) == '0) ? S_DONE : S_RSELF;
            end
          end else begin
            if (cnt_q == '0) begin
              stat_d  = mmtpq_pkg::STAT_EMPTY;
              state_d = S_DONE;
            end else begin
              pos_d   = CW'(1);
              ol_d    = cnt_q;
              state_d = S_DRD;
            end
          end
        end
      end

      // descent along minimum marks
      S_DRD: begin
        raddr   = pos_q;
        state_d = S_DCHK;
      end
      S_DCHK: begin
        pv_d   = rdata.value;
        pmin_d = rdata.smin;
        pmax_d = rdata.smax;
        raddr  = pos_l[CW-1:0];
        if (rdata.value == rdata.smin || !pos_lv) begin
          state_d = S_LAST;
        end else begin
          state_d = S_DCMPL;
        end
      end
      S_DCMPL: begin
        if (rdata.smin == pmin_q) begin
          pos_d   = pos_l[CW-1:0];
          state_d = S_DRD;
        end else if (pos_rv) begin
          pos_d   = pos_r[CW-1:0];
          state_d = S_DRD;
        end else begin
          state_d = S_LAST;
        end
      end

      // move the last value into the freed slot
      S_LAST: begin
        raddr   = ol_q;
        state_d = S_FILL;
      end
      S_FILL: begin
        we     = 1'b1;
        waddr  = pos_q;
        wdata  = '{value: rdata.value, smin: pmin_q, smax: pmax_q};
        res_d  = pv_q;
        cnt_d  = cnt_q - CW'(1);
        if (pos_q < cnt_q) begin
          rk_d    = pos_q;
          pend_d  = 1'b1;
          state_d = S_RSELF;
        end else begin
          rk_d    = ol_q >> 1;
          pend_d  = 1'b0;
          state_d = ((ol_q >> 1) == '0) ? S_DONE : S_RSELF;
        end
      end

      // recompute marks of node rk from itself and its children
      S_RSELF: begin
        raddr   = rk_q;
        state_d = S_RL;
      end
      S_RL: begin
        kv_d    = rdata.value;
        lo_d    = rdata.value;
        hi_d    = rdata.value;
        raddr   = rk_lv ? rk_l[CW-1:0] : rk_q;
        state_d = S_RR;
      end
      S_RR: begin
        if (rk_lv) begin
          if (rdata.smin < lo_q) lo_d = rdata.smin;
          if (rdata.smax > hi_q) hi_d = rdata.smax;
        end
        raddr   = rk_rv ? rk_r[CW-1:0] : rk_q;
        state_d = S_RW;
      end
      S_RW: begin
        we    = 1'b1;
        waddr = rk_q;
        if ((rk_q >> 1) != '0) begin
          rk_d    = rk_q >> 1;
          state_d = S_RSELF;
        end else if (pend_q) begin
          pend_d  = 1'b0;
          rk_d    = ol_q >> 1;
          state_d = ((ol_q >> 1) == '0) ? S_DONE : S_RSELF;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (load_out)                ov_q <= 1'b1;
      else if (!out_stall_i)       ov_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    ol_q   <= ol_d;
    rk_q   <= rk_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    kv_q   <= kv_d;
    pv_q   <= pv_d;
    pmin_q <= pmin_d;
    pmax_q <= pmax_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    if (load_out) begin
      ores_q  <= res_q;
      ostat_q <= stat_q;
      oocc_q  <= cnt_ext[OW-1:0];
    end
  end

  assign out_valid_o    = ov_q;
  assign result_value_o = ores_q;
  assign status_o       = ostat_q;
  assign occupancy_o    = oocc_q;

endmodule
`default_nettype wire

@@ rtl/mmtpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mmtpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
